// ===== hdl/ccs_pkg.sv =====
`timescale 1ns / 1ps

package ccs_pkg;

  // Vector store geometry and number formats
  localparam int VECTOR_DEPTH = 1024;
  localparam int VALUE_BITS   = 16;
  localparam int ACC_BITS     = 40;
  localparam int ROW_BITS     = 16;

  // Fixed field widths of the channels
  localparam int OP_BITS    = 2;
  localparam int INDEX_BITS = 10;

  localparam int ADDR_BITS = $clog2(VECTOR_DEPTH);
  localparam int PROD_BITS = 2 * VALUE_BITS;
  localparam int TERM_BITS = PROD_BITS + 1;
  localparam int SUM_BITS  = ((ACC_BITS > TERM_BITS) ? ACC_BITS : TERM_BITS) + 1;

  // Operation codes of the input channel; code 3 carries no meaning
  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_ROW_END = 2'd2
  } op_t;

endpackage

// ===== hdl/ccs_in_if.sv =====
`timescale 1ns / 1ps

interface ccs_in_if import ccs_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [OP_BITS-1:0]           op;
  logic [INDEX_BITS-1:0]        index;
  logic signed [VALUE_BITS-1:0] value_real;
  logic signed [VALUE_BITS-1:0] value_imag;
  logic                         end_of_row;
  logic                         final_row;

  modport source (
    output valid, op, index, value_real, value_imag, end_of_row, final_row,
    input  ready
  );

  modport sink (
    input  valid, op, index, value_real, value_imag, end_of_row, final_row,
    output ready
  );
endinterface

// ===== hdl/ccs_out_if.sv =====
`timescale 1ns / 1ps

interface ccs_out_if import ccs_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [ROW_BITS-1:0]        row_index;
  logic signed [ACC_BITS-1:0] sum_real;
  logic signed [ACC_BITS-1:0] sum_imag;
  logic                       last_row;

  modport source (
    output valid, row_index, sum_real, sum_imag, last_row,
    input  ready
  );

  modport sink (
    input  valid, row_index, sum_real, sum_imag, last_row,
    output ready
  );
endinterface

// ===== hdl/ccs_ram.sv =====
`timescale 1ns / 1ps

module ccs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/complex_csr_spmv.sv =====
`timescale 1ns / 1ps
// Complex sparse matrix times dense vector, rows in compressed-row order.
// Input channel in_ch: op 0 writes one vector element into the vector store,
// op 1 carries a matrix nonzero (column index plus Q1.15 complex value) and
// op 2 closes the row without adding to it. A nonzero with end_of_row set
// closes its row as well; final_row on the closing item ends the pass.
// Result channel out_ch: one transfer per closed row with the row index,
// the saturated Q10.30 complex row sum and last_row.
// Load every vector element a nonzero will use before sending the matrix.
// Throughput: one input transfer per cycle, any item mix, while out_ch is ready.
// A closing item accepted on in_ch reaches out_ch through stage 1, where
// the vector store is read, stage 2, which holds the complex products, and
// the output register, where the accumulate lands.
// Reset (rst_n low at a clock edge) clears the pipeline, the accumulator
// and the row counter; the vector store keeps its contents and must be
// loaded again before use.
// When the receiver stalls, the result holds in the output register while
// items keep flowing into the two pipeline stages; in_ch.ready falls only
// once a closing item in the last stage finds the output register full.

module complex_csr_spmv import ccs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ccs_in_if.sink    in_ch,
  ccs_out_if.source out_ch
);

  // ---------------------------------------------------------------- control
  logic in_fire;
  logic in_range;
  logic out_free;
  logic s1_open;
  logic s1_adv;
  logic s2_open;
  logic s2_adv;
  logic s2_emit;

  // Stage 1: waiting on the vector store read
  logic                         s1_valid_r;
  logic                         s1_nz_r;
  logic                         s1_hit_r;
  logic signed [VALUE_BITS-1:0] s1_xr_r;
  logic signed [VALUE_BITS-1:0] s1_xi_r;
  logic                         s1_eor_r;
  logic                         s1_fin_r;

  // Stage 2: products ready for the accumulator
  logic                         s2_valid_r;
  logic                         s2_nz_r;
  logic                         s2_eor_r;
  logic                         s2_fin_r;
  logic signed [PROD_BITS-1:0]  s2_prr_r;
  logic signed [PROD_BITS-1:0]  s2_pii_r;
  logic signed [PROD_BITS-1:0]  s2_pri_r;
  logic signed [PROD_BITS-1:0]  s2_pir_r;

  // Row state
  logic signed [ACC_BITS-1:0] acc_real_r;
  logic signed [ACC_BITS-1:0] acc_imag_r;
  logic signed [ACC_BITS-1:0] acc_real_nxt;
  logic signed [ACC_BITS-1:0] acc_imag_nxt;
  logic [ROW_BITS-1:0]        row_cnt_r;

  // Output register
  logic                       out_valid_r;
  logic [ROW_BITS-1:0]        out_row_r;
  logic signed [ACC_BITS-1:0] out_real_r;
  logic signed [ACC_BITS-1:0] out_imag_r;
  logic                       out_last_r;

  // Vector store read data and its selected value
  logic [2*VALUE_BITS-1:0]      ram_rd_data;
  logic signed [VALUE_BITS-1:0] vec_r;
  logic signed [VALUE_BITS-1:0] vec_i;

  // Combined terms and saturated sums
  logic signed [TERM_BITS-1:0] term_r;
  logic signed [TERM_BITS-1:0] term_i;
  logic signed [SUM_BITS-1:0]  sum_r;
  logic signed [SUM_BITS-1:0]  sum_i;
  logic signed [SUM_BITS-1:0]  acc_max;
  logic signed [SUM_BITS-1:0]  acc_min;

  // ------------------------------------------------------------- handshake
  // Each stage advances when the one after it is empty or advancing.
  assign out_free = !out_valid_r || out_ch.ready;
  assign s2_emit  = !s2_nz_r || s2_eor_r;
  assign s2_adv   = s2_valid_r && (!s2_emit || out_free);
  assign s2_open  = !s2_valid_r || s2_adv;
  assign s1_adv   = s1_valid_r && s2_open;
  assign s1_open  = !s1_valid_r || s1_adv;

  assign in_ch.ready = s1_open;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.index) < VECTOR_DEPTH;

  // ----------------------------------------------------------- vector store
  // A load and a nonzero never share a cycle, and a load finishes at its
  // own transfer edge, so a read issued right after a write sees it.
  ccs_ram #(
    .WIDTH (2 * VALUE_BITS),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk     (clk),
    .wr_en   (in_fire && (in_ch.op == OP_LOAD) && in_range),
    .wr_addr (ADDR_BITS'(in_ch.index)),
    .wr_data ({in_ch.value_real, in_ch.value_imag}),
    .rd_en   (in_fire && (in_ch.op == OP_NONZERO)),
    .rd_addr (ADDR_BITS'(in_ch.index)),
    .rd_data (ram_rd_data)
  );

  // Columns past the store read as zero
  assign vec_r = s1_hit_r ? $signed(ram_rd_data[2*VALUE_BITS-1:VALUE_BITS])
                          : '0;
  assign vec_i = s1_hit_r ? $signed(ram_rd_data[VALUE_BITS-1:0]) : '0;

  // ---------------------------------------------------------------- stage 1
  // Loads and unused codes leave nothing behind in the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_open) begin
      s1_valid_r <= in_fire && ((in_ch.op == OP_NONZERO) || (in_ch.op == OP_ROW_END));
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_nz_r  <= in_ch.op == OP_NONZERO;
      s1_hit_r <= in_range;
      s1_xr_r  <= in_ch.value_real;
      s1_xi_r  <= in_ch.value_imag;
      s1_eor_r <= in_ch.end_of_row;
      s1_fin_r <= in_ch.final_row;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_open) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // Four partial products of the complex multiply, registered
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_nz_r  <= s1_nz_r;
      s2_eor_r <= s1_eor_r;
      s2_fin_r <= s1_fin_r;
      s2_prr_r <= PROD_BITS'(s1_xr_r * vec_r);
      s2_pii_r <= PROD_BITS'(s1_xi_r * vec_i);
      s2_pri_r <= PROD_BITS'(s1_xr_r * vec_i);
      s2_pir_r <= PROD_BITS'(s1_xi_r * vec_r);
    end
  end

  // ------------------------------------------------------------ accumulate
  assign acc_max = SUM_BITS'($signed({1'b0, {(ACC_BITS-1){1'b1}}}));
  assign acc_min = ~acc_max;

  always_comb begin
    term_r = TERM_BITS'(s2_prr_r) - TERM_BITS'(s2_pii_r);
    term_i = TERM_BITS'(s2_pri_r) + TERM_BITS'(s2_pir_r);
    // Row ends without entry add nothing
    if (!s2_nz_r) begin
      term_r = '0;
      term_i = '0;
    end
    sum_r = SUM_BITS'(acc_real_r) + SUM_BITS'(term_r);
    sum_i = SUM_BITS'(acc_imag_r) + SUM_BITS'(term_i);
    // Clamp to the accumulator range
    if (sum_r > acc_max) begin
      acc_real_nxt = ACC_BITS'(acc_max);
    end else if (sum_r < acc_min) begin
      acc_real_nxt = ACC_BITS'(acc_min);
    end else begin
      acc_real_nxt = ACC_BITS'(sum_r);
    end
    if (sum_i > acc_max) begin
      acc_imag_nxt = ACC_BITS'(acc_max);
    end else if (sum_i < acc_min) begin
      acc_imag_nxt = ACC_BITS'(acc_min);
    end else begin
      acc_imag_nxt = ACC_BITS'(sum_i);
    end
  end

  // On a row close clear the accumulator and advance the row count, or zero it on final
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_real_r <= '0;
      acc_imag_r <= '0;
      row_cnt_r  <= '0;
    end else if (s2_adv) begin
      if (s2_emit) begin
        acc_real_r <= '0;
        acc_imag_r <= '0;
        row_cnt_r  <= s2_fin_r ? '0 : row_cnt_r + 1'b1;
      end else begin
        acc_real_r <= acc_real_nxt;
        acc_imag_r <= acc_imag_nxt;
      end
    end
  end

  // ---------------------------------------------------------- output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv && s2_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_emit) begin
      out_row_r  <= row_cnt_r;
      out_real_r <= acc_real_nxt;
      out_imag_r <= acc_imag_nxt;
      out_last_r <= s2_fin_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_index = out_row_r;
  assign out_ch.sum_real  = out_real_r;
  assign out_ch.sum_imag  = out_imag_r;
  assign out_ch.last_row  = out_last_r;

  // ------------------------------------------------------------ assertions
  // A closing item held back by a full output register stays in stage 2
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_emit && !out_free) |=> s2_valid_r)
    else $error("closing item dropped while output register was full");

  // The accumulator starts every row from zero
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && s2_emit) |=> (acc_real_r == '0) && (acc_imag_r == '0))
    else $error("accumulator not cleared after row close");

  // The row count restarts after the last row of a pass
  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && s2_emit && s2_fin_r) |=> (row_cnt_r == '0))
    else $error("row counter did not restart after final row");

  // A nonzero or row end taken in always reaches stage 1
  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ((in_ch.op == OP_NONZERO) || (in_ch.op == OP_ROW_END))) |=> s1_valid_r)
    else $error("accepted item lost before stage 1");

endmodule

// ===== dv/tb_complex_csr_spmv.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the complex sparse matrix-vector block.
// An initial block builds the item list: a directed opening, two rows long
// enough to drive the accumulator into saturation, then random matrix passes
// mixed with vector reloads, noise codes and malformed rows. A clocked driver
// sends the list with random gaps. On every accepted transfer it runs the
// bench's own model of the block, which queues the expected row sums. A
// clocked monitor stalls the result side at random and checks each row sum
// against the oldest expected one.

module tb_complex_csr_spmv;
  import ccs_pkg::*;

  // Unused op code: the block must swallow it without a trace
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [VALUE_BITS-1:0] Q_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] Q_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam longint ACC_HI = (longint'(1) << (ACC_BITS - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  localparam int RANDOM_ITEMS = 80;
  localparam int SAT_RUN      = 270;  // nonzeros per saturating row, needs > 257
  localparam int MAX_WAIT     = 16;

  typedef struct {
    logic [OP_BITS-1:0]           op;
    logic [INDEX_BITS-1:0]        index;
    logic signed [VALUE_BITS-1:0] re;
    logic signed [VALUE_BITS-1:0] im;
    logic                         eor;
    logic                         fin;
    bit                           hold_for_drain;
  } spmv_item_t;

  typedef struct {
    logic [ROW_BITS-1:0]        row_index;
    logic signed [ACC_BITS-1:0] sum_real;
    logic signed [ACC_BITS-1:0] sum_imag;
    logic                       last_row;
  } row_sum_t;

  logic clk = 1'b0;
  logic rst_n;

  ccs_in_if  in_ch ();
  ccs_out_if out_ch ();

  complex_csr_spmv dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;

  // Stimulus list and the expected row sums still owed by the block
  spmv_item_t pending_items[$];
  row_sum_t   sums_due[$];

  // Bench-side copy of the block state
  logic signed [VALUE_BITS-1:0] vec_re [VECTOR_DEPTH];
  logic signed [VALUE_BITS-1:0] vec_im [VECTOR_DEPTH];
  longint                       acc_re;
  longint                       acc_im;
  logic [ROW_BITS-1:0]          row_count;

  // Generator bookkeeping: columns that hold a written vector element
  bit         loaded [VECTOR_DEPTH];
  int         loaded_cols[$];
  bit         hold_next;
  int         random_count;

  // Run statistics
  int n_loads, n_nonzeros, n_row_ends, n_ignored;
  int rows_predicted, passes_done, rail_sums, rows_checked, errors;

  // ---------------------------------------------------------------------------
  // Model of the block
  // ---------------------------------------------------------------------------

  // Emit the accumulator as the row sum, clear it and advance the row counter.
  function automatic void close_row(logic fin);
    row_sum_t r;
    r.row_index = row_count;
    r.sum_real  = acc_re[ACC_BITS-1:0];
    r.sum_imag  = acc_im[ACC_BITS-1:0];
    r.last_row  = fin;
    sums_due.push_back(r);
    if (acc_re == ACC_HI || acc_re == ACC_LO || acc_im == ACC_HI || acc_im == ACC_LO)
      rail_sums++;
    acc_re = 0;
    acc_im = 0;
    row_count = fin ? '0 : row_count + 1'b1;
    rows_predicted++;
    if (fin)
      passes_done++;
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > ACC_HI)
      return ACC_HI;
    if (v < ACC_LO)
      return ACC_LO;
    return v;
  endfunction

  function automatic void accumulate_item(spmv_item_t it);
    longint xr, xi, vr, vi;
    xr = it.re;
    xi = it.im;
    case (it.op)
      OP_LOAD: begin
        vec_re[it.index] = it.re;
        vec_im[it.index] = it.im;
        n_loads++;
      end
      OP_NONZERO: begin
        vr = vec_re[it.index];
        vi = vec_im[it.index];
        // Terms stay within 33 bits at Q1.15, so the 64-bit sums never overflow
        acc_re = clamp_acc(acc_re + (xr * vr - xi * vi));
        acc_im = clamp_acc(acc_im + (xr * vi + xi * vr));
        n_nonzeros++;
        if (it.eor)
          close_row(it.fin);
      end
      OP_ROW_END: begin
        n_row_ends++;
        close_row(it.fin);
      end
      default: n_ignored++;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic void push_item(logic [OP_BITS-1:0] op, int idx,
                                    logic signed [VALUE_BITS-1:0] re,
                                    logic signed [VALUE_BITS-1:0] im,
                                    logic eor, logic fin);
    spmv_item_t it;
    it.op             = op;
    it.index          = idx[INDEX_BITS-1:0];
    it.re             = re;
    it.im             = im;
    it.eor            = eor;
    it.fin            = fin;
    it.hold_for_drain = hold_next;
    hold_next = 1'b0;
    pending_items.push_back(it);
    if (op == OP_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
    if (op != OP_UNUSED)
      random_count++;
  endfunction

  // Lean toward the extremes so the corner products show up often
  function automatic logic signed [VALUE_BITS-1:0] rand_q15();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Only columns that were loaded may be read
  function automatic int rand_col();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  function automatic void push_noise();
    push_item(OP_UNUSED, $urandom_range(0, VECTOR_DEPTH - 1),
              VALUE_BITS'($urandom), VALUE_BITS'($urandom),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // One row closing its sum; mostly well formed, sometimes left open so that
  // its nonzeros spill into the next row.
  function automatic void push_row(logic fin);
    int n;
    if ($urandom_range(0, 99) < 15) begin
      push_item(OP_ROW_END, $urandom_range(0, VECTOR_DEPTH - 1),
                VALUE_BITS'($urandom), VALUE_BITS'($urandom),
                1'($urandom_range(0, 1)), fin);
      return;
    end
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 49) == 0)
        push_noise();
      if (k == n - 1)
        push_item(OP_NONZERO, rand_col(), rand_q15(), rand_q15(),
                  $urandom_range(0, 19) != 0, fin);
      else
        push_item(OP_NONZERO, rand_col(), rand_q15(), rand_q15(), 1'b0,
                  1'($urandom_range(0, 1)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one transfer per item, random gap after each one
  // ---------------------------------------------------------------------------
  spmv_item_t cur_item;
  int         in_gap;
  bit         in_burst;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_fire)
        accumulate_item(cur_item);
      if (in_gap != 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].hold_for_drain && sums_due.size() != 0)) begin
        // nothing left, or hold until the block has delivered every row sum
        in_ch.valid <= 1'b0;
      end else begin
        cur_item = pending_items.pop_front();
        in_ch.op         <= cur_item.op;
        in_ch.index      <= cur_item.index;
        in_ch.value_real <= cur_item.re;
        in_ch.value_imag <= cur_item.im;
        in_ch.end_of_row <= cur_item.eor;
        in_ch.final_row  <= cur_item.fin;
        in_ch.valid      <= 1'b1;
        if ($urandom_range(0, 29) == 0)
          in_burst = !in_burst;
        in_gap <= in_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls, check each row sum against the oldest expected
  // ---------------------------------------------------------------------------
  int out_stall;
  bit out_burst;

  function automatic void report_error(string what);
    errors++;
    if (errors <= 10)
      $display("%0t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    row_sum_t exp_sum;
    int       d;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_fire) begin
      if (sums_due.size() == 0) begin
        report_error($sformatf("unexpected row sum: row %0d re %0d im %0d last %0b",
                               out_ch.row_index, out_ch.sum_real, out_ch.sum_imag,
                               out_ch.last_row));
      end else begin
        exp_sum = sums_due.pop_front();
        rows_checked++;
        if (out_ch.row_index !== exp_sum.row_index || out_ch.sum_real !== exp_sum.sum_real ||
            out_ch.sum_imag !== exp_sum.sum_imag || out_ch.last_row !== exp_sum.last_row)
          report_error($sformatf({"row sum mismatch: expected row %0d re %0d im %0d last %0b,",
                                  " got row %0d re %0d im %0d last %0b"},
                                 exp_sum.row_index, exp_sum.sum_real, exp_sum.sum_imag,
                                 exp_sum.last_row, out_ch.row_index, out_ch.sum_real,
                                 out_ch.sum_imag, out_ch.last_row));
      end
      if ($urandom_range(0, 19) == 0)
        out_burst = !out_burst;
      d = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      out_stall    <= d;
      out_ch.ready <= (d == 0);
    end else if (!out_ch.ready) begin
      if (out_stall == 0)
        out_ch.ready <= 1'b1;
      else
        out_stall <= out_stall - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int drain_cycles;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_LOAD;
    in_ch.index      = '0;
    in_ch.value_real = '0;
    in_ch.value_imag = '0;
    in_ch.end_of_row = 1'b0;
    in_ch.final_row  = 1'b0;
    out_ch.ready     = 1'b0;
    acc_re           = 0;
    acc_im           = 0;
    row_count        = '0;

    // Directed opening: corner values, every op, ignored flags, empty rows,
    // a single-row pass and a row end without entry that closes open nonzeros.
    push_item(OP_LOAD, 0, Q_MIN, Q_MIN, 1'b1, 1'b1);
    push_item(OP_LOAD, VECTOR_DEPTH - 1, Q_MAX, Q_MIN, 1'b0, 1'b0);
    push_item(OP_LOAD, 1, 16'sd1, -16'sd1, 1'b0, 1'b0);
    push_item(OP_LOAD, 512, '0, '0, 1'b0, 1'b1);
    push_item(OP_UNUSED, VECTOR_DEPTH - 1, -16'sd1, -16'sd1, 1'b1, 1'b1);
    push_item(OP_NONZERO, 0, Q_MIN, Q_MIN, 1'b1, 1'b0);
    push_item(OP_ROW_END, 0, '0, '0, 1'b0, 1'b0);
    push_item(OP_NONZERO, VECTOR_DEPTH - 1, Q_MAX, Q_MAX, 1'b0, 1'b1);
    push_item(OP_NONZERO, 1, -16'sd1, 16'sd1, 1'b0, 1'b0);
    push_item(OP_UNUSED, 0, '0, '0, 1'b0, 1'b0);
    push_item(OP_NONZERO, 512, 16'sd12345, -16'sd12345, 1'b0, 1'b0);
    push_item(OP_NONZERO, 0, Q_MAX, Q_MIN, 1'b1, 1'b0);
    push_item(OP_ROW_END, 1023, Q_MAX, Q_MAX, 1'b1, 1'b0);
    push_item(OP_NONZERO, VECTOR_DEPTH - 1, Q_MIN, Q_MAX, 1'b1, 1'b1);
    push_item(OP_ROW_END, 0, '0, '0, 1'b0, 1'b1);
    push_item(OP_NONZERO, 1, Q_MAX, Q_MAX, 1'b0, 1'b0);
    push_item(OP_ROW_END, 0, '0, '0, 1'b0, 1'b0);
    push_item(OP_LOAD, 1, '0, Q_MIN, 1'b1, 1'b0);
    push_item(OP_NONZERO, 1, Q_MIN, '0, 1'b1, 1'b1);

    // Saturation: each term is close to 2^31, so about 257 of them reach the
    // 40-bit rail; two opposite terms then pull the sum back off the rail.
    hold_next = 1'b1;
    push_item(OP_LOAD, 2, Q_MIN, Q_MAX, 1'b0, 1'b0);
    push_item(OP_LOAD, 3, Q_MIN, Q_MIN, 1'b0, 1'b0);
    repeat (SAT_RUN)
      push_item(OP_NONZERO, 2, Q_MIN, Q_MIN, 1'b0, 1'($urandom_range(0, 1)));
    push_item(OP_NONZERO, 2, Q_MAX, Q_MAX, 1'b0, 1'b0);
    push_item(OP_NONZERO, 2, Q_MAX, Q_MAX, 1'b1, 1'b0);
    repeat (SAT_RUN)
      push_item(OP_NONZERO, 3, Q_MAX, Q_MAX, 1'b0, 1'b0);
    push_item(OP_NONZERO, 3, Q_MIN, Q_MIN, 1'b0, 1'b0);
    push_item(OP_NONZERO, 3, Q_MIN, Q_MIN, 1'b1, 1'b1);

    // Random part: mostly whole passes with random content, plus reloads,
    // noise codes, left-open rows and passes that never mark a final row.
    hold_next = 1'b1;
    random_count = 0;
    repeat (16)
      push_item(OP_LOAD, $urandom_range(0, VECTOR_DEPTH - 1), rand_q15(), rand_q15(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    while (random_count < RANDOM_ITEMS) begin
      int rows;
      int pick;
      if (random_count > RANDOM_ITEMS / 2 && random_count < RANDOM_ITEMS / 2 + 8)
        hold_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        repeat ($urandom_range(1, 6))
          push_item(OP_LOAD, $urandom_range(0, VECTOR_DEPTH - 1), rand_q15(), rand_q15(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 23) begin
        push_noise();
      end else begin
        rows = $urandom_range(1, 6);
        for (int r = 0; r < rows; r++)
          push_row(r == rows - 1 && $urandom_range(0, 9) != 0);
      end
    end

    // Hold reset low, then release it at a clock edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_ch.valid)
      @(negedge clk);
    drain_cycles = 0;
    while (sums_due.size() != 0 && drain_cycles < 4000) begin
      @(negedge clk);
      drain_cycles++;
    end
    // keep running so a stray extra result still gets caught
    repeat (8) @(negedge clk);
    if (sums_due.size() != 0) begin
      $display("%0d expected row sums never arrived", sums_due.size());
      errors += sums_due.size();
    end

    $display("Sent %0d transfers: %0d vector loads, %0d nonzeros, %0d empty-row ends, %0d ignored",
             n_loads + n_nonzeros + n_row_ends + n_ignored, n_loads, n_nonzeros, n_row_ends,
             n_ignored);
    $display("Checked %0d row sums over %0d passes, %0d on a saturation rail, %0d errors",
             rows_checked, passes_done, rail_sums, errors);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this item count
  initial begin
    #20ms;
    $display("Timeout with %0d items unsent and %0d row sums outstanding",
             pending_items.size(), sums_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
